### rtl/core/slc_pkg.sv
// Shared types and constants for the sequence list engine.
// No dependencies; used by slc_cell, slc_ctrl and sequence_list_engine_core.
package slc_pkg;

  localparam int Depth  = 32;
  localparam int RunCap = 32;
  localparam int ValW   = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ_FIRST = 3'd5,
    OP_READ_LAST  = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD    = 2'd0,
    CM_SHIFT_R = 2'd1,
    CM_ROTATE  = 2'd2,
    CM_LOAD    = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t        mode;
    logic [ValW-1:0]   value;
  } cell_cmd_t;

endpackage

### rtl/core/slc_cell.sv
// One list cell: holds the entry at list position INDEX.
// Depends on slc_pkg for the cell command struct.
module slc_cell #(
  parameter int DEPTH = slc_pkg::Depth,
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  slc_pkg::cell_cmd_t               cmd,
  input  logic [$clog2(DEPTH+1)-1:0]       len,
  input  logic [slc_pkg::ValW-1:0]         left,
  input  logic [slc_pkg::ValW-1:0]         right,
  input  logic [slc_pkg::ValW-1:0]         head,
  output logic [slc_pkg::ValW-1:0]         data
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [slc_pkg::ValW-1:0] data_next;

  always_comb begin
    case (cmd.mode)
      slc_pkg::CM_HOLD:    data_next = data;
      slc_pkg::CM_SHIFT_R: data_next = left;
      slc_pkg::CM_ROTATE:  data_next = (CW'(INDEX + 1) == len) ? head : right;
      slc_pkg::CM_LOAD:    data_next = (CW'(INDEX) == len) ? cmd.value : data;
      default:             data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### rtl/core/slc_ctrl.sv
// Sequencer for the list engine: takes words, steers the cell row, counts
// entries and drives the result register. Depends on slc_pkg.
module slc_ctrl #(
  parameter int DEPTH = slc_pkg::Depth
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [2:0]                       operation,
  input  logic signed [31:0]               item_value,
  input  logic [5:0]                       count_limit,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic signed [31:0]               out_value,
  output logic                             last_of_run,
  output logic [1:0]                       status,
  output logic [5:0]                       occupancy,
  input  logic [slc_pkg::ValW-1:0]         head,
  output slc_pkg::cell_cmd_t               cmd,
  output logic [$clog2(DEPTH+1)-1:0]       len
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t                   state;
  slc_pkg::op_t             op;
  logic [slc_pkg::ValW-1:0] val;
  logic [5:0]               lim;
  logic [CW-1:0]            count;
  logic [CW-1:0]            steps;
  logic [CW-1:0]            idx;

  logic                     out_free;
  logic                     emit;
  logic                     done;
  logic [slc_pkg::ValW-1:0] e_val;
  logic                     e_last;
  slc_pkg::status_t         e_status;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            idx_next;
  logic [31:0]              n_w;
  logic [31:0]              occ_w;
  logic [CW-1:0]            rd_n;
  logic [CW-1:0]            rd_start;
  logic [CW-1:0]            rd_stop;
  logic                     in_window;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign len       = count;

  always_comb begin
    n_w = (32'(lim) < 32'(count)) ? 32'(lim) : 32'(count);
    if (n_w > 32'(slc_pkg::RunCap)) n_w = 32'(slc_pkg::RunCap);
    rd_n = CW'(n_w);
    if (op == slc_pkg::OP_READ_FIRST) begin
      rd_start = '0;
      rd_stop  = rd_n - CW'(1);
    end else begin
      rd_start = count - rd_n;
      rd_stop  = count - CW'(1);
    end
    in_window = (idx >= rd_start) && (idx <= rd_stop);
  end

  always_comb begin
    cmd.mode   = slc_pkg::CM_HOLD;
    cmd.value  = val;
    emit       = 1'b0;
    done       = 1'b0;
    e_val      = '0;
    e_last     = 1'b1;
    e_status   = slc_pkg::ST_OK;
    count_next = count;
    idx_next   = idx;
    if (state == S_RUN) begin
      unique case (op) inside
        slc_pkg::OP_PUSH_FRONT, slc_pkg::OP_PUSH_BACK: begin
          if (out_free) begin
            emit = 1'b1;
            done = 1'b1;
            if (count == CW'(DEPTH)) begin
              e_status = slc_pkg::ST_FULL;
            end else begin
              cmd.mode   = (op == slc_pkg::OP_PUSH_FRONT) ? slc_pkg::CM_SHIFT_R
                                                          : slc_pkg::CM_LOAD;
              count_next = count + CW'(1);
            end
          end
        end
        slc_pkg::OP_POP_FRONT, slc_pkg::OP_POP_BACK: begin
          if (out_free) begin
            emit = 1'b1;
            done = 1'b1;
            if (count == '0) begin
              e_status = slc_pkg::ST_EMPTY;
            end else begin
              cmd.mode   = (op == slc_pkg::OP_POP_FRONT) ? slc_pkg::CM_ROTATE
                                                         : slc_pkg::CM_HOLD;
              count_next = count - CW'(1);
            end
          end
        end
        slc_pkg::OP_REMOVE: begin
          if (idx != steps) begin
            // front entry goes to the back unless it matches
            cmd.mode = slc_pkg::CM_ROTATE;
            idx_next = idx + CW'(1);
            if (head == val) count_next = count - CW'(1);
          end else if (out_free) begin
            emit = 1'b1;
            done = 1'b1;
          end
        end
        slc_pkg::OP_READ_FIRST, slc_pkg::OP_READ_LAST: begin
          if (count == '0) begin
            if (out_free) begin
              emit     = 1'b1;
              done     = 1'b1;
              e_status = slc_pkg::ST_EMPTY;
            end
          end else if (rd_n == '0) begin
            if (out_free) begin
              emit = 1'b1;
              done = 1'b1;
            end
          end else if (!in_window || out_free) begin
            // one full rotation restores the list
            cmd.mode = slc_pkg::CM_ROTATE;
            idx_next = idx + CW'(1);
            emit     = in_window;
            e_val    = head;
            e_last   = (idx == rd_stop);
            done     = (idx == count - CW'(1));
          end
        end
        slc_pkg::OP_CLEAR: begin
          if (out_free) begin
            emit       = 1'b1;
            done       = 1'b1;
            count_next = '0;
          end
        end
      endcase
    end
    occ_w = 32'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_RUN;
            op    <= slc_pkg::op_t'(operation);
            val   <= item_value;
            lim   <= count_limit;
            steps <= count;
            idx   <= '0;
          end
        end
        S_RUN: begin
          count <= count_next;
          idx   <= idx_next;
          if (done) state <= S_IDLE;
        end
      endcase
      if (emit) begin
        rsp_valid   <= 1'b1;
        out_value   <= e_val;
        last_of_run <= e_last;
        status      <= e_status;
        occupancy   <= occ_w[5:0];
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("engine not busy after accepting a word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |=> $stable(count))
    else $error("entry count moved while idle");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN && op == slc_pkg::OP_REMOVE |=> count <= $past(count))
    else $error("remove grew the list");

endmodule

### rtl/core/sequence_list_engine_core.sv
// Sequence list engine top level: a row of DEPTH cells holding the list in
// order (cell 0 is the front) plus the sequencer. Depends on slc_pkg,
// slc_cell and slc_ctrl.
//
// The engine takes one word, works on it, and takes the next once it is
// done; a result waiting in the output register does not hold off the next
// word. A push, pop or clear is accepted and then done in one step once the
// output register is free. Remove and read walk the list by rotating the
// cell row one position per cycle; a read of an empty list or of zero
// entries only returns a status word. A read emits one word per cycle from
// the front cell and holds its rotation while the result side stalls. Reads
// return the list unchanged after a full rotation.
module sequence_list_engine_core #(
  parameter int DEPTH = slc_pkg::Depth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [2:0]          operation,
  input  logic signed [31:0]  item_value,
  input  logic [5:0]          count_limit,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic signed [31:0]  out_value,
  output logic                last_of_run,
  output logic [1:0]          status,
  output logic [5:0]          occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  slc_pkg::cell_cmd_t       cmd;
  logic [CW-1:0]            len;
  logic [slc_pkg::ValW-1:0] cell_data [DEPTH];

  slc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .item_value  (item_value),
    .count_limit (count_limit),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .out_value   (out_value),
    .last_of_run (last_of_run),
    .status      (status),
    .occupancy   (occupancy),
    .head        (cell_data[0]),
    .cmd         (cmd),
    .len         (len)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [slc_pkg::ValW-1:0] left_in;
    logic [slc_pkg::ValW-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = cmd.value;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = cell_data[0];
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    slc_cell #(.DEPTH(DEPTH), .INDEX(g)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .len   (len),
      .left  (left_in),
      .right (right_in),
      .head  (cell_data[0]),
      .data  (cell_data[g])
    );
  end

endmodule

### sim/tb_sequence_list_engine_core.sv
// Self-checking testbench for sequence_list_engine_core: directed and random list
// operations with random idling and stalls, each result checked against a list predictor.
// Depends on slc_pkg and the sequence_list_engine_core RTL.
module tb_sequence_list_engine_core;

  localparam int HoldCycles    = 200;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 80;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    slc_pkg::status_t   st;
    logic [5:0]         occ;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [2:0]         operation = slc_pkg::OP_CLEAR;
  logic signed [31:0] item_value = '0;
  logic [5:0]         count_limit = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] out_value;
  logic               last_of_run;
  logic [1:0]         status;
  logic [5:0]         occupancy;

  logic signed [31:0] list_q[$];
  list_result_t       pending_results[$];
  int                 failures = 0;
  int                 quiet_cycles = 0;
  bit                 idle_on = 1'b1;
  bit                 stall_on = 1'b1;
  bit                 long_hold_req = 1'b0;
  bit                 long_hold_done = 1'b0;

  sequence_list_engine_core dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .item_value (item_value),
    .count_limit(count_limit),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_value  (out_value),
    .last_of_run(last_of_run),
    .status     (status),
    .occupancy  (occupancy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void add_status(slc_pkg::status_t st);
    list_result_t r;
    r.value = '0;
    r.last  = 1'b1;
    r.st    = st;
    r.occ   = 6'(list_q.size());
    pending_results.push_back(r);
  endfunction

  function automatic void predict_word(slc_pkg::op_t op, logic signed [31:0] val,
                                       logic [5:0] cnt);
    logic signed [31:0] kept_q[$];
    list_result_t       r;
    int                 n;
    int                 start;
    case (op) inside
      slc_pkg::OP_PUSH_FRONT, slc_pkg::OP_PUSH_BACK: begin
        if (list_q.size() >= slc_pkg::Depth) begin
          add_status(slc_pkg::ST_FULL);
        end else begin
          if (op == slc_pkg::OP_PUSH_FRONT) list_q.push_front(val);
          else list_q.push_back(val);
          add_status(slc_pkg::ST_OK);
        end
      end
      slc_pkg::OP_POP_FRONT, slc_pkg::OP_POP_BACK: begin
        if (list_q.size() == 0) begin
          add_status(slc_pkg::ST_EMPTY);
        end else begin
          if (op == slc_pkg::OP_POP_FRONT) void'(list_q.pop_front());
          else void'(list_q.pop_back());
          add_status(slc_pkg::ST_OK);
        end
      end
      slc_pkg::OP_REMOVE: begin
        foreach (list_q[i]) if (list_q[i] != val) kept_q.push_back(list_q[i]);
        list_q = kept_q;
        add_status(slc_pkg::ST_OK);
      end
      slc_pkg::OP_READ_FIRST, slc_pkg::OP_READ_LAST: begin
        n = cnt;
        if (n > slc_pkg::Depth) n = slc_pkg::Depth;
        if (n > list_q.size()) n = list_q.size();
        if (n > slc_pkg::RunCap) n = slc_pkg::RunCap;
        if (list_q.size() == 0) begin
          add_status(slc_pkg::ST_EMPTY);
        end else if (n == 0) begin
          add_status(slc_pkg::ST_OK);
        end else begin
          start = (op == slc_pkg::OP_READ_FIRST) ? 0 : list_q.size() - n;
          for (int i = 0; i < n; i++) begin
            r.value = list_q[start + i];
            r.last  = (i == n - 1);
            r.st    = slc_pkg::ST_OK;
            r.occ   = 6'(list_q.size());
            pending_results.push_back(r);
          end
        end
      end
      default: begin
        list_q.delete();
        add_status(slc_pkg::ST_OK);
      end
    endcase
  endfunction

  task automatic send_word(slc_pkg::op_t op, logic signed [31:0] val, logic [5:0] cnt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    item_value  <= val;
    count_limit <= cnt;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_word(op, val, cnt);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if (list_q.size() != 0 && $urandom_range(0, 2) == 0)
      return list_q[$urandom_range(0, list_q.size() - 1)];
    if ($urandom_range(0, 3) != 0) return 32'($signed($urandom_range(0, 6)) - 3);
    return $urandom;
  endfunction

  // Response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word value=%0d last=%0b status=%0d occ=%0d",
                 $time, out_value, last_of_run, status, occupancy);
        failures++;
      end else begin
        list_result_t e;
        e = pending_results.pop_front();
        if (out_value !== e.value) begin
          $display("%0t: out_value expected %0d actual %0d", $time, e.value, out_value);
          failures++;
        end
        if (last_of_run !== e.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, e.last, last_of_run);
          failures++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          failures++;
        end
        if (occupancy !== e.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occupancy);
          failures++;
        end
      end
    end
  end

  // Receiver stalls
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        rsp_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rsp_stall <= 1'b0;
        long_hold_done = 1'b1;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_sequence_list_engine_core NOT OK");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_word(slc_pkg::OP_READ_FIRST, 32'sd0, 6'd5);
    send_word(slc_pkg::OP_READ_LAST, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_POP_FRONT, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_POP_BACK, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_REMOVE, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_CLEAR, 32'sd0, 6'd0);
  endtask

  task automatic test_push_pop_edges();
    send_word(slc_pkg::OP_PUSH_FRONT, 32'sh7fffffff, 6'd0);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sh80000000, 6'd0);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sd0, 6'd63);
    send_word(slc_pkg::OP_PUSH_FRONT, -32'sd1, 6'd0);
    send_word(slc_pkg::OP_READ_FIRST, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_READ_FIRST, 32'sd0, 6'd63);
    send_word(slc_pkg::OP_READ_LAST, 32'sd0, 6'd2);
    send_word(slc_pkg::OP_POP_FRONT, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_POP_BACK, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_READ_LAST, 32'sd0, 6'd32);
  endtask

  task automatic test_remove();
    send_word(slc_pkg::OP_CLEAR, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sd5, 6'd0);
    send_word(slc_pkg::OP_REMOVE, 32'sd5, 6'd0);
    send_word(slc_pkg::OP_READ_FIRST, 32'sd0, 6'd1);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sd7, 6'd0);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sd5, 6'd0);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sd7, 6'd0);
    send_word(slc_pkg::OP_PUSH_FRONT, 32'sd9, 6'd0);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sd7, 6'd0);
    send_word(slc_pkg::OP_REMOVE, 32'sd7, 6'd0);
    send_word(slc_pkg::OP_REMOVE, 32'sd100, 6'd0);
    send_word(slc_pkg::OP_READ_FIRST, 32'sd0, 6'd32);
  endtask

  task automatic test_full_list();
    send_word(slc_pkg::OP_CLEAR, 32'sd0, 6'd0);
    for (int i = 0; i < slc_pkg::Depth; i++)
      send_word(slc_pkg::OP_PUSH_BACK, pick_value(), 6'd0);
    send_word(slc_pkg::OP_PUSH_FRONT, 32'sd1, 6'd0);
    send_word(slc_pkg::OP_PUSH_BACK, 32'sd1, 6'd0);
    send_word(slc_pkg::OP_READ_FIRST, 32'sd0, 6'd32);
    send_word(slc_pkg::OP_READ_LAST, 32'sd0, 6'd40);
    send_word(slc_pkg::OP_POP_FRONT, 32'sd0, 6'd0);
    send_word(slc_pkg::OP_PUSH_FRONT, 32'sh80000000, 6'd0);
    send_word(slc_pkg::OP_READ_LAST, 32'sd0, 6'd63);
    send_word(slc_pkg::OP_REMOVE, list_q[slc_pkg::Depth / 2], 6'd0);
    send_word(slc_pkg::OP_READ_FIRST, 32'sd0, 6'd33);
  endtask

  task automatic test_random_mix(int n_words, int push_pct);
    int           r;
    slc_pkg::op_t op;
    logic [5:0]   cnt;
    for (int k = 0; k < n_words; k++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct)
        op = ($urandom_range(0, 1) == 0) ? slc_pkg::OP_PUSH_FRONT : slc_pkg::OP_PUSH_BACK;
      else if (r < 70)
        op = ($urandom_range(0, 1) == 0) ? slc_pkg::OP_POP_FRONT : slc_pkg::OP_POP_BACK;
      else if (r < 80)
        op = slc_pkg::OP_REMOVE;
      else if (r < 98)
        op = ($urandom_range(0, 1) == 0) ? slc_pkg::OP_READ_FIRST : slc_pkg::OP_READ_LAST;
      else
        op = slc_pkg::OP_CLEAR;
      cnt = ($urandom_range(0, 19) == 0) ? 6'($urandom) : 6'($urandom_range(0, 33));
      send_word(op, pick_value(), cnt);
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    for (int k = 0; k < 20; k++) send_word(slc_pkg::OP_PUSH_BACK, $urandom, 6'd0);
    for (int k = 0; k < 10; k++) begin
      send_word(slc_pkg::OP_READ_LAST, 32'sd0, 6'($urandom_range(0, 40)));
      send_word(slc_pkg::OP_REMOVE, pick_value(), 6'd0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_push_pop_edges();
    test_remove();
    wait_drained();
    test_full_list();
    test_random_mix(130, 55);
    wait_drained();
    test_random_mix(110, 35);
    wait_drained();
    test_backpressure();
    wait_drained();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random_mix(80, 45);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0)
      $display("tb_sequence_list_engine_core OK");
    else
      $display("tb_sequence_list_engine_core NOT OK");
    $finish;
  end

endmodule
